[src/json_string_unescape_utf8_check_macros.svh]
// Assertion macros used by the top level of the string decoder.
`ifndef JSON_STRING_UNESCAPE_UTF8_CHECK_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CHECK_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JSUU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSUU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/jsuu_pkg.sv]
// Types, codes and helper functions of the JSON string decoder.
package jsuu_pkg;

    // Result status codes
    localparam logic [3:0] ST_DATA         = 4'd0;
    localparam logic [3:0] ST_OK           = 4'd1;
    localparam logic [3:0] ST_NO_QUOTE     = 4'd2;
    localparam logic [3:0] ST_CONTROL      = 4'd3;
    localparam logic [3:0] ST_BAD_ESCAPE   = 4'd4;
    localparam logic [3:0] ST_END_ESCAPE   = 4'd5;
    localparam logic [3:0] ST_BAD_HEX      = 4'd6;
    localparam logic [3:0] ST_END_HEX      = 4'd7;
    localparam logic [3:0] ST_NO_LOW_SUR   = 4'd8;
    localparam logic [3:0] ST_BAD_LOW_SUR  = 4'd9;
    localparam logic [3:0] ST_LONE_LOW_SUR = 4'd10;
    localparam logic [3:0] ST_BAD_UTF8     = 4'd11;
    localparam logic [3:0] ST_UNTERMINATED = 4'd12;

    // Continuation limit codes of the validator
    localparam logic [1:0] RANGE_ANY  = 2'd0;
    localparam logic [1:0] RANGE_LOW  = 2'd1;
    localparam logic [1:0] RANGE_HIGH = 2'd2;

    // Characters with a role in the syntax
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Surrogate bounds
    localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SUR_LOW_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] status;
        logic       last;
    } out_item_t;

    // All results caused by one input transfer
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0]      status;
        logic [3:0][7:0] bytes;
    } bundle_t;

    typedef struct packed {
        logic [1:0] pending;
        logic [1:0] range;
        logic       bad;
    } utf8_state_t;

    // Hex digit value; bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Advance the well-formed UTF-8 check by one byte
    function automatic utf8_state_t utf8_check(input utf8_state_t s, input logic [7:0] b);
        utf8_state_t n;
        logic [7:0]  lo;
        logic [7:0]  hi;
        n  = s;
        lo = 8'h80;
        hi = 8'hBF;
        if (!s.bad) begin
            if (s.pending == 2'd0) begin
                if (b <= 8'h7F) begin
                    n = s;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    n.pending = 2'd1;
                    n.range   = RANGE_ANY;
                end else if (b == 8'hE0) begin
                    n.pending = 2'd2;
                    n.range   = RANGE_LOW;
                end else if (b == 8'hED) begin
                    n.pending = 2'd2;
                    n.range   = RANGE_HIGH;
                end else if (b >= 8'hE1 && b <= 8'hEF) begin
                    n.pending = 2'd2;
                    n.range   = RANGE_ANY;
                end else if (b == 8'hF0) begin
                    n.pending = 2'd3;
                    n.range   = RANGE_LOW;
                end else if (b >= 8'hF1 && b <= 8'hF3) begin
                    n.pending = 2'd3;
                    n.range   = RANGE_ANY;
                end else if (b == 8'hF4) begin
                    n.pending = 2'd3;
                    n.range   = RANGE_HIGH;
                end else begin
                    n.bad = 1'b1;
                end
            end else begin
                if (s.pending == 2'd2 && s.range == RANGE_LOW)  lo = 8'hA0;
                if (s.pending == 2'd2 && s.range == RANGE_HIGH) hi = 8'h9F;
                if (s.pending == 2'd3 && s.range == RANGE_LOW)  lo = 8'h90;
                if (s.pending == 2'd3 && s.range == RANGE_HIGH) hi = 8'h8F;
                if (b >= lo && b <= hi) begin
                    n.pending = s.pending - 2'd1;
                    n.range   = RANGE_ANY;
                end else begin
                    n.bad     = 1'b1;
                    n.pending = 2'd0;
                    n.range   = RANGE_ANY;
                end
            end
        end
        return n;
    endfunction

endpackage

[src/json_string_unescape_utf8_check.sv]
// Top level of the JSON string decoder with UTF-8 check.
//
//  channel   direction  payload      handshake
//  byte      in         in_item_t    byte_valid / byte_stall
//  result    out        out_item_t   result_valid / result_stall
//
// An input byte is decoded in the cycle it transfers; its 0 to 4 results
// are held in a result register and leave one per cycle from the next cycle
// while the result side does not stall. A byte giving at most one result
// sustains one transfer per cycle while result_stall is low; a \u escape
// giving n bytes stalls the input while the result register drains or stalls.
// The input is taken while the last held result transfers.
// Reset clears the parse state and empties the result register.
module json_string_unescape_utf8_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  jsuu_pkg::in_item_t  byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output jsuu_pkg::out_item_t result_data
);
    import jsuu_pkg::*;
    `include "json_string_unescape_utf8_check_macros.svh"

    bundle_t    bundle;
    bundle_t    bundle_reg;
    logic [1:0] pos_reg;
    logic       valid_reg;
    logic       take;
    logic       out_xfer;
    logic       at_last;

    jsuu_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (byte_data),
        .bundle (bundle)
    );

    // Handshake of both sides
    assign out_xfer   = valid_reg && !result_stall;
    assign at_last    = ({1'b0, pos_reg} == (bundle_reg.count - 3'd1));
    assign byte_stall = valid_reg && !(out_xfer && at_last);
    assign take       = byte_valid && !byte_stall;

    // Present the current result
    assign result_valid         = valid_reg;
    assign result_data.out_byte = bundle_reg.bytes[pos_reg];
    assign result_data.status   = bundle_reg.status;
    assign result_data.last     = at_last;

    // Hold the drain position and the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (take && bundle.count != 3'd0) begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end else if (out_xfer) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // Load the results of a new transfer
    always_ff @(posedge clk)
    begin
        if (take && bundle.count != 3'd0) begin
            bundle_reg <= bundle;
        end
    end

    `JSUU_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !valid_reg, !byte_stall, "input stalled with empty result register")
    `JSUU_ASSERT_NOW(a_pos_in_range, clk, rst_n, valid_reg, ({1'b0, pos_reg} < bundle_reg.count), "drain position past result count")
    `JSUU_ASSERT_NOW(a_status_single, clk, rst_n, valid_reg && bundle_reg.status != ST_DATA, result_data.last && result_data.out_byte == 8'd0, "status result not alone or not zero")
    `JSUU_ASSERT_NEXT(a_empty_after_last, clk, rst_n, out_xfer && at_last && !take, !valid_reg, "result register not empty after last transfer")

endmodule

[src/jsuu_decode.sv]
// Parse state and per-byte decode of one JSON string literal.
module jsuu_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  jsuu_pkg::in_item_t item,
    output jsuu_pkg::bundle_t  bundle
);
    import jsuu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_BSL2,
        PH_U2,
        PH_HEX2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_sur_reg, high_sur_next;
    utf8_state_t utf8_reg, utf8_next;

    logic            fin;
    logic [3:0]      fin_code;
    logic [2:0]      n_out;
    logic [3:0][7:0] b_out;
    logic            do_enc;
    logic [20:0]     cp;
    logic [4:0]      hexv;
    logic [15:0]     v16;
    logic [7:0]      c;
    logic            eoi;

    assign c    = item.in_byte;
    assign eoi  = item.end_of_input;
    assign hexv = hex_digit(c);
    assign v16  = {hex_accum_reg[11:0], hexv[3:0]};

    // Decode one byte into next state and its results
    always_comb
    begin
        phase_next     = phase_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        high_sur_next  = high_sur_reg;
        utf8_next      = utf8_reg;
        fin            = 1'b0;
        fin_code       = ST_DATA;
        n_out          = 3'd0;
        b_out          = '0;
        do_enc         = 1'b0;
        cp             = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (eoi || c != CH_QUOTE) begin
                    fin      = 1'b1;
                    fin_code = ST_NO_QUOTE;
                end else begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (eoi) begin
                    fin      = 1'b1;
                    fin_code = ST_UNTERMINATED;
                end else if (c == CH_QUOTE) begin
                    fin      = 1'b1;
                    fin_code = (utf8_reg.bad || utf8_reg.pending != 2'd0) ? ST_BAD_UTF8 : ST_OK;
                end else if (c < CH_SPACE) begin
                    fin      = 1'b1;
                    fin_code = ST_CONTROL;
                end else if (c == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    n_out    = 3'd1;
                    b_out[0] = c;
                end
            end
            PH_ESC:
            begin
                if (eoi) begin
                    fin      = 1'b1;
                    fin_code = ST_END_ESCAPE;
                end else begin
                    phase_next = PH_BODY;
                    n_out      = 3'd1;
                    case (c)
                        CH_QUOTE:  b_out[0] = CH_QUOTE;
                        CH_BSLASH: b_out[0] = CH_BSLASH;
                        CH_SLASH:  b_out[0] = CH_SLASH;
                        8'h62:     b_out[0] = 8'h08;
                        8'h66:     b_out[0] = 8'h0C;
                        8'h6E:     b_out[0] = 8'h0A;
                        8'h72:     b_out[0] = 8'h0D;
                        8'h74:     b_out[0] = 8'h09;
                        CH_LOW_U:
                        begin
                            n_out          = 3'd0;
                            phase_next     = PH_HEX1;
                            hex_accum_next = '0;
                            hex_count_next = '0;
                        end
                        default:
                        begin
                            fin      = 1'b1;
                            fin_code = ST_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (eoi) begin
                    fin      = 1'b1;
                    fin_code = ST_END_HEX;
                end else if (!hexv[4]) begin
                    fin      = 1'b1;
                    fin_code = ST_BAD_HEX;
                end else if (hex_count_reg != 2'd3) begin
                    hex_accum_next = v16;
                    hex_count_next = hex_count_reg + 2'd1;
                end else begin
                    hex_accum_next = '0;
                    hex_count_next = '0;
                    if (phase_reg == PH_HEX1) begin
                        if (v16 >= SUR_HIGH_MIN && v16 <= SUR_HIGH_MAX) begin
                            high_sur_next = v16[9:0];
                            phase_next    = PH_BSL2;
                        end else if (v16 >= SUR_LOW_MIN && v16 <= SUR_LOW_MAX) begin
                            fin      = 1'b1;
                            fin_code = ST_LONE_LOW_SUR;
                        end else begin
                            phase_next = PH_BODY;
                            do_enc     = 1'b1;
                            cp         = {5'd0, v16};
                        end
                    end else begin
                        if (!(v16 >= SUR_LOW_MIN && v16 <= SUR_LOW_MAX)) begin
                            fin      = 1'b1;
                            fin_code = ST_BAD_LOW_SUR;
                        end else begin
                            phase_next    = PH_BODY;
                            do_enc        = 1'b1;
                            cp            = SUPP_BASE + {1'b0, high_sur_reg, v16[9:0]};
                            high_sur_next = '0;
                        end
                    end
                end
            end
            PH_BSL2:
            begin
                if (eoi || c != CH_BSLASH) begin
                    fin      = 1'b1;
                    fin_code = ST_NO_LOW_SUR;
                end else begin
                    phase_next = PH_U2;
                end
            end
            PH_U2:
            begin
                if (eoi || c != CH_LOW_U) begin
                    fin      = 1'b1;
                    fin_code = ST_NO_LOW_SUR;
                end else begin
                    phase_next     = PH_HEX2;
                    hex_accum_next = '0;
                    hex_count_next = '0;
                end
            end
            default:
            begin
                fin      = 1'b1;
                fin_code = ST_NO_QUOTE;
            end
        endcase

        // Encode a code point as UTF-8
        if (do_enc) begin
            if (cp <= 21'h7F) begin
                n_out    = 3'd1;
                b_out[0] = cp[7:0];
            end else if (cp <= 21'h7FF) begin
                n_out    = 3'd2;
                b_out[0] = {3'b110, cp[10:6]};
                b_out[1] = {2'b10, cp[5:0]};
            end else if (cp <= 21'hFFFF) begin
                n_out    = 3'd3;
                b_out[0] = {4'b1110, cp[15:12]};
                b_out[1] = {2'b10, cp[11:6]};
                b_out[2] = {2'b10, cp[5:0]};
            end else begin
                n_out    = 3'd4;
                b_out[0] = {5'b11110, cp[20:18]};
                b_out[1] = {2'b10, cp[17:12]};
                b_out[2] = {2'b10, cp[11:6]};
                b_out[3] = {2'b10, cp[5:0]};
            end
        end

        // Run emitted bytes through the validator in order
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n_out) begin
                utf8_next = utf8_check(utf8_next, b_out[i]);
            end
        end

        // Drop all state at the end of a string or on an error
        if (fin) begin
            phase_next     = PH_IDLE;
            hex_accum_next = '0;
            hex_count_next = '0;
            high_sur_next  = '0;
            utf8_next      = '0;
            bundle.count   = 3'd1;
            bundle.status  = fin_code;
            bundle.bytes   = '0;
        end else begin
            bundle.count   = n_out;
            bundle.status  = ST_DATA;
            bundle.bytes   = b_out;
        end
    end

    // Hold parse state; advance on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            hex_accum_reg <= '0;
            hex_count_reg <= '0;
            high_sur_reg  <= '0;
            utf8_reg      <= '0;
        end else if (take) begin
            phase_reg     <= phase_next;
            hex_accum_reg <= hex_accum_next;
            hex_count_reg <= hex_count_next;
            high_sur_reg  <= high_sur_next;
            utf8_reg      <= utf8_next;
        end
    end

endmodule
